FILE: hdl/pcu_pkg.sv
// Shared types, constants and helpers for the polynomial curve unwrap block.
// No dependencies; every other file imports this package.
`default_nettype none
package pcu_pkg;

  localparam int NUM_COEFFS = 6;
  localparam int IDX_W      = $clog2(NUM_COEFFS);
  localparam int Y_W        = 49;
  localparam int D_W        = 50;

  localparam logic signed [63:0]    Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0]    ONE_Q32 = 64'sh0000_0001_0000_0000;
  localparam logic signed [D_W-1:0] LIMIT_Q = 50'sd429497;
  localparam logic signed [Y_W-1:0] STEP_Q  = 49'sd42949673;
  localparam logic [46:0]           ARC_MAX = 47'h7FFF_FFFF_FFFF;
  localparam logic signed [63:0]    X48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]    X48_MIN = -64'sh0000_8000_0000_0000;

  localparam logic [2:0] CFG_MIN_Y = 3'd6;
  localparam logic [2:0] CFG_MAX_Y = 3'd7;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic signed [47:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] foot_y;
    logic signed [47:0] foot_x;
    logic [46:0]        arc_length;
    logic signed [47:0] height;
    logic               bracket_error;
  } out_word_t;

  typedef enum logic [1:0] {MUL_Q48, MUL_Q32, MUL_RAW} mul_mode_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_EV_INIT, OP_TERM_GO, OP_TERM_TAKE, OP_DT_GO, OP_DT_TAKE,
    OP_DER_ADD, OP_POW_GO, OP_POW_TAKE, OP_E, OP_F_GO, OP_F_TAKE, OP_LO_SIGN,
    OP_HI_SIGN, OP_SET_ERR, OP_Y_MID, OP_BIS_UPD, OP_Y_LO, OP_FX, OP_Y_T, OP_SQX_GO,
    OP_SQX_TAKE, OP_SQY_GO, OP_SQ_SUM, OP_SQRT_GO, OP_ARC_UPD, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic i_last;
    logic k_last;
    logic bracket_bad;
    logic wide;
    logic t_below;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (b == 64'sd0) return a;
    if (s > 65'(Q_MAX)) return Q_MAX;
    if (s < -65'(Q_MAX)) return -Q_MAX;
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/polynomial_curve_unwrap.sv
// Top level of the polynomial curve unwrap block: controller plus datapath.
// Depends on pcu_pkg, pcu_ctrl and pcu_dpath.
//
//   port group | direction | handshake          | word
//   in_*       | input     | in_valid/in_stall   | pcu_pkg::in_word_t
//   out_*      | output    | out_valid/out_stall | pcu_pkg::out_word_t
//   cfg_*      | input     | cfg_we              | 64-bit data, 3-bit index
//
// One curve evaluation with its foot-point sign is paced by the single shared
// 64x64 multiplier and the serial derivative sums.
// A point takes 3+B curve evaluations for B bisection steps, plus one for each of
// G grid points from foot to max_y; each grid point adds two squares and a
// bit-serial root.
// Synchronous active-low reset clears control state and configuration registers; no clearing pass.
// A finished word waits in the output register while the next point is taken.
`default_nettype none
module polynomial_curve_unwrap (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pcu_pkg::in_word_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pcu_pkg::out_word_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata
);
  import pcu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without work in progress");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block idle right after taking a word");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.mul_done && stat.sqrt_done))
    else $error("multiplier and root unit finished together");
`endif

endmodule
`default_nettype wire

FILE: hdl/pcu_mul.sv
// Iterative signed 64x64 multiplier: four 32x32 partial products, round, saturate.
// Depends on pcu_pkg.
`default_nettype none
module pcu_mul (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [63:0]      a,
  input  wire logic signed [63:0]      b,
  input  wire pcu_pkg::mul_mode_t      mode,
  output logic                         done,
  output logic signed [63:0]           res_q,
  output logic [127:0]                 res_raw
);
  import pcu_pkg::*;

  logic [63:0]        am_r, bm_r;
  logic               neg_r;
  mul_mode_t          mode_r;
  logic [127:0]       acc_r;
  logic [2:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [63:0] res_r;
  logic [31:0]        a_sel, b_sel;
  logic [63:0]        pp;
  logic [127:0]       pp_sh, rnd, shifted;
  logic [63:0]        m;

  always_comb begin
    a_sel   = cnt_r[1] ? am_r[63:32] : am_r[31:0];
    b_sel   = cnt_r[0] ? bm_r[63:32] : bm_r[31:0];
    pp      = a_sel * b_sel;
    pp_sh   = {64'b0, pp} << {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'b0};
    case (mode_r)
      MUL_Q48: rnd = 128'h1 << 47;
      MUL_Q32: rnd = 128'h1 << 31;
      default: rnd = '0;
    endcase
    shifted = (mode_r == MUL_Q48) ? (acc_r >> 48) : (acc_r >> 32);
    m       = (|shifted[127:63]) ? Q_MAX : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r   <= a[63] ? 64'(-a) : 64'(a);
      bm_r   <= b[63] ? 64'(-b) : 64'(b);
      neg_r  <= a[63] ^ b[63];
      mode_r <= mode;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) acc_r <= acc_r + pp_sh;
      else if (cnt_r == 3'd4) acc_r <= acc_r + rnd;
      else res_r <= neg_r ? -$signed(m) : $signed(m);
    end
  end

  assign done    = done_r;
  assign res_q   = res_r;
  assign res_raw = acc_r;

endmodule
`default_nettype wire

FILE: hdl/pcu_sqrt.sv
// Bit-serial floor square root of a 128-bit value, one root bit per cycle.
// Depends on pcu_pkg.
`default_nettype none
module pcu_sqrt (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] rad,
  output logic              done,
  output logic [63:0]       root
);
  import pcu_pkg::*;

  logic [127:0] rad_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic [5:0]   cnt_r;
  logic         busy_r, done_r;
  logic [67:0]  rem_s, trial;
  logic         fits;

  always_comb begin
    rem_s = {rem_r, rad_r[127:126]};
    trial = {2'b0, root_r, 2'b01};
    fits  = rem_s >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? 66'(rem_s - trial) : rem_s[65:0];
      root_r <= {root_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

FILE: hdl/pcu_dpath.sv
// Datapath: configuration registers, point and search registers, output word.
// Depends on pcu_pkg, pcu_mul and pcu_sqrt.
`default_nettype none
module pcu_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_wdata,
  input  wire pcu_pkg::in_word_t   in_data,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output pcu_pkg::out_word_t       out_data,
  input  wire pcu_pkg::dp_cmd_t    cmd,
  output pcu_pkg::dp_stat_t        stat
);
  import pcu_pkg::*;

  logic signed [63:0]    coeff_r [NUM_COEFFS];
  logic signed [47:0]    min_y_r, max_y_r;
  logic signed [47:0]    px_r, py_r, pz_r;
  logic signed [Y_W-1:0] lo_r, hi_r, y_r, t_r, yprev_r;
  logic signed [63:0]    p_r, accx_r, accd_r, term_r, e_r, xprev_r, fx_r;
  logic [62:0]           dym_r;
  logic [127:0]          sq_r;
  logic [46:0]           len_r;
  logic                  err_r;
  logic [1:0]            sgn_lo_r, sgn_hi_r, s_r;
  logic [IDX_W-1:0]      i_r, k_r;
  out_word_t             out_r;
  logic                  out_valid_r;

  logic                  mul_start, mul_done, sqrt_start, sqrt_done;
  logic signed [63:0]    mul_a, mul_b, mul_res;
  mul_mode_t             mul_mode;
  logic [127:0]          mul_raw;
  logic [63:0]           root;
  logic signed [D_W-1:0] diff_hl, diff_t;
  logic [D_W-1:0]        dxm;
  logic signed [63:0]    xd, fval;
  logic [62:0]           dym;
  logic signed [Y_W-1:0] mid;
  logic [47:0]           fx48;
  logic [IDX_W-1:0]      i_nx;

  always_comb begin
    diff_hl = D_W'(hi_r) - D_W'(lo_r);
    mid     = lo_r + $signed(diff_hl[Y_W:1]);
    diff_t  = D_W'(t_r) - D_W'(yprev_r);
    dxm     = diff_t[D_W-1] ? D_W'(-diff_t) : D_W'(diff_t);
    xd      = sat_add(accx_r, -xprev_r);
    dym     = xd[63] ? 63'(-xd) : xd[62:0];
    fval    = sat_add(64'(y_r) - 64'(py_r), mul_res);
    i_nx    = i_r + 1'b1;
    if (fx_r > X48_MAX) fx48 = X48_MAX[47:0];
    else if (fx_r < X48_MIN) fx48 = X48_MIN[47:0];
    else fx48 = fx_r[47:0];
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a     = p_r;
    mul_b     = p_r;
    mul_mode  = MUL_Q32;
    case (cmd.op)
      OP_TERM_GO: begin
        mul_a    = coeff_r[i_r];
        mul_mode = MUL_Q48;
      end
      OP_DT_GO: begin
        mul_a    = coeff_r[i_nx];
        mul_mode = MUL_Q48;
      end
      OP_POW_GO: mul_b = 64'(y_r);
      OP_F_GO: begin
        mul_a = accd_r;
        mul_b = e_r;
      end
      OP_SQX_GO: begin
        mul_a    = $signed(64'(dxm));
        mul_b    = $signed(64'(dxm));
        mul_mode = MUL_RAW;
      end
      OP_SQY_GO: begin
        mul_a    = $signed({1'b0, dym_r});
        mul_b    = $signed({1'b0, dym_r});
        mul_mode = MUL_RAW;
      end
      default: mul_start = 1'b0;
    endcase
    sqrt_start = (cmd.op == OP_SQRT_GO);
  end

  pcu_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .mode    (mul_mode),
    .done    (mul_done),
    .res_q   (mul_res),
    .res_raw (mul_raw)
  );

  pcu_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sq_r),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NUM_COEFFS; n++) coeff_r[n] <= '0;
      min_y_r     <= '0;
      max_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_Y) min_y_r <= cfg_wdata[47:0];
        else if (cfg_index == CFG_MAX_Y) max_y_r <= cfg_wdata[47:0];
        else if (32'(cfg_index) < NUM_COEFFS) coeff_r[cfg_index[IDX_W-1:0]] <= cfg_wdata;
      end
      if (cmd.op == OP_DONE) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        px_r  <= in_data.point_x;
        py_r  <= in_data.point_y;
        pz_r  <= in_data.point_z;
        lo_r  <= Y_W'(min_y_r);
        hi_r  <= Y_W'(max_y_r);
        y_r   <= Y_W'(min_y_r);
        err_r <= 1'b0;
        len_r <= '0;
      end
      OP_EV_INIT: begin
        accx_r <= '0;
        accd_r <= '0;
        p_r    <= ONE_Q32;
        i_r    <= '0;
      end
      OP_TERM_TAKE: accx_r <= sat_add(accx_r, mul_res);
      OP_DT_TAKE: begin
        term_r <= mul_res;
        k_r    <= '0;
      end
      OP_DER_ADD: begin
        accd_r <= sat_add(accd_r, term_r);
        k_r    <= k_r + 1'b1;
      end
      OP_POW_TAKE: begin
        p_r <= mul_res;
        i_r <= i_r + 1'b1;
      end
      OP_E: e_r <= sat_add(accx_r, -64'(px_r));
      OP_F_TAKE: s_r <= {fval < 0, fval != 0};
      OP_LO_SIGN: begin
        sgn_lo_r <= s_r;
        y_r      <= hi_r;
      end
      OP_HI_SIGN: sgn_hi_r <= s_r;
      OP_SET_ERR: err_r <= 1'b1;
      OP_Y_MID: y_r <= mid;
      OP_BIS_UPD: begin
        if (s_r[0] && sgn_hi_r[0] && (s_r[1] != sgn_hi_r[1])) begin
          lo_r <= y_r;
        end else begin
          hi_r     <= y_r;
          sgn_hi_r <= s_r;
        end
      end
      OP_Y_LO: y_r <= lo_r;
      OP_FX: begin
        fx_r    <= accx_r;
        xprev_r <= accx_r;
        yprev_r <= lo_r;
        t_r     <= lo_r;
      end
      OP_Y_T: y_r <= t_r;
      OP_SQX_GO: dym_r <= dym;
      OP_SQX_TAKE: sq_r <= mul_raw;
      OP_SQ_SUM: sq_r <= sq_r + mul_raw;
      OP_ARC_UPD: begin
        if (root > 64'(ARC_MAX - len_r)) len_r <= ARC_MAX;
        else len_r <= len_r + root[46:0];
        yprev_r <= t_r;
        xprev_r <= accx_r;
        t_r     <= t_r + STEP_Q;
      end
      OP_DONE: begin
        out_r.foot_y        <= lo_r[47:0];
        out_r.foot_x        <= fx48;
        out_r.arc_length    <= len_r;
        out_r.height        <= pz_r;
        out_r.bracket_error <= err_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.mul_done    = mul_done;
    stat.sqrt_done   = sqrt_done;
    stat.i_last      = (32'(i_r) == NUM_COEFFS - 1);
    stat.k_last      = (k_r == i_r);
    stat.bracket_bad = sgn_lo_r[0] && sgn_hi_r[0] && (sgn_lo_r[1] == sgn_hi_r[1]);
    stat.wide        = diff_hl > LIMIT_Q;
    stat.t_below     = t_r < Y_W'(max_y_r);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: hdl/pcu_ctrl.sv
// Controller: sequences curve evaluation, bisection, arc walk and result handoff.
// Depends on pcu_pkg.
`default_nettype none
module pcu_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pcu_pkg::dp_stat_t  stat,
  output pcu_pkg::dp_cmd_t        cmd
);
  import pcu_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE    = 23'h000001,
    S_EV_INIT = 23'h000002,
    S_TERM_GO = 23'h000004,
    S_TERM_W  = 23'h000008,
    S_DER     = 23'h000010,
    S_POW_GO  = 23'h000020,
    S_POW_W   = 23'h000040,
    S_E       = 23'h000080,
    S_F_GO    = 23'h000100,
    S_F_W     = 23'h000200,
    S_RET     = 23'h000400,
    S_BRACKET = 23'h000800,
    S_BIS     = 23'h001000,
    S_FX      = 23'h002000,
    S_ARC     = 23'h004000,
    S_SQX_W   = 23'h008000,
    S_SQY_GO  = 23'h010000,
    S_SQY_W   = 23'h020000,
    S_SQRT_GO = 23'h040000,
    S_SQRT_W  = 23'h080000,
    S_DONE    = 23'h100000,
    S_DT_GO   = 23'h200000,
    S_DT_W    = 23'h400000
  } state_t;

  typedef enum logic [2:0] {PH_LO, PH_HI, PH_MID, PH_FX, PH_ARC} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          phase_nxt = PH_LO;
          state_nxt = S_EV_INIT;
        end
      end
      S_EV_INIT: begin
        cmd.op    = OP_EV_INIT;
        state_nxt = S_TERM_GO;
      end
      S_TERM_GO: begin
        cmd.op    = OP_TERM_GO;
        state_nxt = S_TERM_W;
      end
      S_TERM_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_TERM_TAKE;
          state_nxt = stat.i_last ? S_E : S_DT_GO;
        end
      end
      S_DT_GO: begin
        cmd.op    = OP_DT_GO;
        state_nxt = S_DT_W;
      end
      S_DT_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_DT_TAKE;
          state_nxt = S_DER;
        end
      end
      S_DER: begin
        cmd.op = OP_DER_ADD;
        if (stat.k_last) state_nxt = S_POW_GO;
      end
      S_POW_GO: begin
        cmd.op    = OP_POW_GO;
        state_nxt = S_POW_W;
      end
      S_POW_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_POW_TAKE;
          state_nxt = S_TERM_GO;
        end
      end
      S_E: begin
        cmd.op    = OP_E;
        state_nxt = S_F_GO;
      end
      S_F_GO: begin
        cmd.op    = OP_F_GO;
        state_nxt = S_F_W;
      end
      S_F_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_F_TAKE;
          state_nxt = S_RET;
        end
      end
      S_RET: begin
        case (phase_r)
          PH_LO: begin
            cmd.op    = OP_LO_SIGN;
            phase_nxt = PH_HI;
            state_nxt = S_EV_INIT;
          end
          PH_HI: begin
            cmd.op    = OP_HI_SIGN;
            state_nxt = S_BRACKET;
          end
          PH_MID: begin
            cmd.op    = OP_BIS_UPD;
            state_nxt = S_BIS;
          end
          PH_FX: begin
            cmd.op    = OP_FX;
            state_nxt = S_ARC;
          end
          PH_ARC: begin
            cmd.op    = OP_SQX_GO;
            state_nxt = S_SQX_W;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_BRACKET: begin
        if (stat.bracket_bad) begin
          cmd.op    = OP_SET_ERR;
          state_nxt = S_FX;
        end else begin
          state_nxt = S_BIS;
        end
      end
      S_BIS: begin
        if (stat.wide) begin
          cmd.op    = OP_Y_MID;
          phase_nxt = PH_MID;
          state_nxt = S_EV_INIT;
        end else begin
          state_nxt = S_FX;
        end
      end
      S_FX: begin
        cmd.op    = OP_Y_LO;
        phase_nxt = PH_FX;
        state_nxt = S_EV_INIT;
      end
      S_ARC: begin
        if (stat.t_below) begin
          cmd.op    = OP_Y_T;
          phase_nxt = PH_ARC;
          state_nxt = S_EV_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SQX_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_SQX_TAKE;
          state_nxt = S_SQY_GO;
        end
      end
      S_SQY_GO: begin
        cmd.op    = OP_SQY_GO;
        state_nxt = S_SQY_W;
      end
      S_SQY_W: begin
        if (stat.mul_done) begin
          cmd.op    = OP_SQ_SUM;
          state_nxt = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd.op    = OP_SQRT_GO;
        state_nxt = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (stat.sqrt_done) begin
          cmd.op    = OP_ARC_UPD;
          state_nxt = S_ARC;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_LO;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for polynomial_curve_unwrap: random and directed points
// checked against an in-bench fixed-point predictor. Depends on pcu_pkg and the RTL.
module testbench;
  import pcu_pkg::*;

  localparam logic [2:0] CFG_COEFF_0 = 3'd0;
  localparam logic signed [63:0] ONE_Q48   = 64'sh0001_0000_0000_0000;
  localparam logic signed [63:0] HALF_Q48  = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] Y48_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Y48_MIN   = -64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] BIS_LIMIT = 64'sd429497;
  localparam logic signed [63:0] GRID_STEP = 64'sd42949673;
  localparam logic signed [63:0] S64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]        LEN_MAX   = 64'h0000_7FFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_word_t  in_data;
  out_word_t out_data;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  polynomial_curve_unwrap DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic signed [63:0] coeff_reg [NUM_COEFFS];
  logic signed [63:0] min_reg, max_reg;
  in_word_t  points_to_send [$];
  out_word_t expected_feet [$];
  int send_idle, recv_stall, fails, cycles;
  bit took;

  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < -65'(S64_MAX)) return -S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b, input int fb);
    logic [127:0] p;
    logic [63:0] m;
    p = ({64'b0, magnitude(a)} * {64'b0, magnitude(b)}) + (128'd1 << (fb - 1));
    p = p >> fb;
    m = (p > 128'(S64_MAX)) ? 64'(S64_MAX) : p[63:0];
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] curve_value(input logic signed [63:0] y);
    logic signed [63:0] acc, p;
    acc = 0;
    p = ONE_Q32;
    for (int i = 0; i < NUM_COEFFS; i++) begin
      acc = sum_sat(acc, q_mul(coeff_reg[i], p, 48));
      p = q_mul(p, y, 32);
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] curve_slope(input logic signed [63:0] y);
    logic signed [63:0] acc, p, term;
    acc = 0;
    p = ONE_Q32;
    for (int i = 1; i < NUM_COEFFS; i++) begin
      term = q_mul(coeff_reg[i], p, 48);
      for (int k = 0; k < i; k++) acc = sum_sat(acc, term);
      p = q_mul(p, y, 32);
    end
    return acc;
  endfunction

  function automatic int foot_sign(input logic signed [63:0] y, px, py);
    logic signed [63:0] f;
    f = sum_sat(y - py, q_mul(curve_slope(y), sum_sat(curve_value(y), -px), 32));
    return f > 0 ? 1 : (f < 0 ? -1 : 0);
  endfunction

  function automatic logic [63:0] chord_root(input logic [127:0] n);
    logic [63:0] r, t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'b0, t} * {64'b0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic out_word_t project_point(input in_word_t w);
    logic signed [63:0] px, py, lo, hi, mid, fx, t, yprev, xprev, xt;
    logic [63:0] len, seg, dxm, dym;
    out_word_t r;
    px = w.point_x;
    py = w.point_y;
    lo = min_reg;
    hi = max_reg;
    len = 0;
    r.bracket_error = 1'b0;
    if (foot_sign(lo, px, py) * foot_sign(hi, px, py) > 0) begin
      r.bracket_error = 1'b1;
    end else begin
      while (hi - lo > BIS_LIMIT) begin
        mid = lo + (hi - lo) / 2;
        if (foot_sign(mid, px, py) * foot_sign(hi, px, py) < 0) lo = mid;
        else hi = mid;
      end
    end
    fx = curve_value(lo);
    yprev = lo;
    xprev = fx;
    for (t = lo; t < max_reg; t += GRID_STEP) begin
      xt = curve_value(t);
      dxm = magnitude(t - yprev);
      dym = magnitude(sum_sat(xt, -xprev));
      seg = chord_root({64'b0, dxm} * {64'b0, dxm} + {64'b0, dym} * {64'b0, dym});
      if (seg > LEN_MAX - len) len = LEN_MAX;
      else len += seg;
      yprev = t;
      xprev = xt;
    end
    if (fx > Y48_MAX) fx = Y48_MAX;
    if (fx < Y48_MIN) fx = Y48_MIN;
    r.foot_y = lo[47:0];
    r.foot_x = fx[47:0];
    r.arc_length = len[46:0];
    r.height = w.point_z;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polynomial_curve_unwrap: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_feet.insert(expected_feet.size(), project_point(in_data));
      took = 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      took = 0;
      if (points_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= points_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_feet.size() == 0) begin
        $error("unexpected word: foot_y %0d", $signed(out_data.foot_y));
        fails++;
      end else begin
        e = expected_feet.pop_front();
        if (out_data.foot_y !== e.foot_y) begin
          $error("foot_y expected %0d actual %0d", $signed(e.foot_y), $signed(out_data.foot_y));
          fails++;
        end
        if (out_data.foot_x !== e.foot_x) begin
          $error("foot_x expected %0d actual %0d", $signed(e.foot_x), $signed(out_data.foot_x));
          fails++;
        end
        if (out_data.arc_length !== e.arc_length) begin
          $error("arc_length expected %0d actual %0d", e.arc_length, out_data.arc_length);
          fails++;
        end
        if (out_data.height !== e.height) begin
          $error("height expected %0d actual %0d", $signed(e.height), $signed(out_data.height));
          fails++;
        end
        if (out_data.bracket_error !== e.bracket_error) begin
          $error("bracket_error expected %0b actual %0b", e.bracket_error,
                 out_data.bracket_error);
          fails++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_MIN_Y) min_reg = $signed(val[47:0]);
    else if (idx == CFG_MAX_Y) max_reg = $signed(val[47:0]);
    else coeff_reg[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_curve(input logic signed [63:0] c0, c1, c2, c3, c4, c5, lo, hi);
    write_reg(CFG_COEFF_0, c0);
    write_reg(CFG_COEFF_0 + 3'd1, c1);
    write_reg(CFG_COEFF_0 + 3'd2, c2);
    write_reg(CFG_COEFF_0 + 3'd3, c3);
    write_reg(CFG_COEFF_0 + 3'd4, c4);
    write_reg(CFG_COEFF_0 + 3'd5, c5);
    write_reg(CFG_MIN_Y, lo);
    write_reg(CFG_MAX_Y, hi);
  endtask

  task automatic drain();
    while (points_to_send.size() != 0 || in_valid || expected_feet.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_point(input logic signed [63:0] px, py, pz);
    in_word_t w;
    w.point_x = px[47:0];
    w.point_y = py[47:0];
    w.point_z = pz[47:0];
    points_to_send.insert(points_to_send.size(), w);
  endtask

  function automatic logic signed [63:0] rand48();
    return $signed({{16{1'b0}}, 48'({$urandom, $urandom})} << 16) >>> 16;
  endfunction

  task automatic random_curve();
    logic signed [63:0] c [6];
    logic signed [63:0] lo;
    for (int i = 0; i < 6; i++) c[i] = $signed({$urandom, $urandom}) >>> (14 + 2 * i);
    lo = 64'($signed($urandom)) * 8;
    if ($urandom_range(9) == 0)
      load_curve(c[0], c[1], c[2], c[3], c[4], c[5], lo, lo - $urandom_range(1000000));
    else
      load_curve(c[0], c[1], c[2], c[3], c[4], c[5], lo, lo + $urandom_range(1288490188));
  endtask

  task automatic random_points(input int n, input bit hold_each);
    logic signed [63:0] py;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        push_point(rand48(), rand48(), rand48());
      end else begin
        py = min_reg - 429496730 + $urandom_range(1288490188);
        push_point(curve_value(py) + $signed(32'($urandom)) / 2, py, rand48());
      end
      if (hold_each) drain();
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle = 0;
    recv_stall = 0;
    fails = 0;
    cycles = 0;
    took = 0;
    for (int i = 0; i < NUM_COEFFS; i++) coeff_reg[i] = 0;
    min_reg = 0;
    max_reg = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    push_point(0, 0, 0);
    push_point(Y48_MAX, Y48_MIN, Y48_MAX);
    drain();

    load_curve(ONE_Q48, 0, HALF_Q48, 0, 0, 0, -64'sd429496730, 64'sd858993459);
    push_point(ONE_Q32, 0, 123);
    push_point(curve_value(min_reg), min_reg, -5);
    push_point(0, 100 * ONE_Q32, 7);
    push_point(Y48_MAX, Y48_MAX, Y48_MAX);
    push_point(Y48_MIN, Y48_MIN, Y48_MIN);
    push_point(-1, -1, -1);
    drain();

    load_curve(S64_MAX, -S64_MAX - 1, S64_MAX, -S64_MAX - 1, S64_MAX, -S64_MAX - 1,
               Y48_MAX, Y48_MIN);
    push_point(0, 0, 1);
    push_point(Y48_MIN, Y48_MAX, 2);
    drain();

    load_curve(S64_MAX, S64_MAX, -S64_MAX - 1, S64_MAX, S64_MAX, S64_MAX,
               Y48_MAX - 214748365, Y48_MAX);
    push_point(Y48_MAX, Y48_MAX - 100000000, 3);
    push_point(0, 0, 4);
    drain();

    load_curve(-S64_MAX - 1, ONE_Q48, 0, 0, 0, -S64_MAX - 1, Y48_MIN, Y48_MIN + 128849018);
    push_point(Y48_MIN, Y48_MIN + 5000000, 5);
    push_point(Y48_MAX, Y48_MIN, 6);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 65) : 0;
      recv_stall = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 65) : 0;
      random_curve();
      random_points(12, 1'b0);
      drain();
      random_curve();
      random_points(12, 1'b0);
      drain();
    end

    send_idle = 0;
    recv_stall = 65;
    random_curve();
    random_points(4, 1'b1);
    drain();
    repeat (200) @(posedge clk);

    if (fails == 0) $display("polynomial_curve_unwrap: match");
    else $display("polynomial_curve_unwrap: mismatch");
    $finish;
  end

endmodule
